[src/ntc_adc_to_temperature_core_defines.svh]
// Assertion macros for the NTC converter checker.
// No dependencies; pulled in by the checker file only.
`ifndef NTC_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define NTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntc check failed");

// Next-cycle implication, disabled while reset is low
`define NTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntc check failed");

`endif

[src/ntc_pkg.sv]
// Shared constants, types and the thermistor curve for the NTC converter.
// No dependencies; used by the interfaces, the divider, the core and the checker.
package ntc_pkg;

    // Converter and scaling
    localparam int ADC_BITS    = 12;
    localparam int ADC_FULL    = 1 << ADC_BITS;
    localparam int R_SCALE     = 1000;
    localparam int R_SCALE_W   = 10;
    localparam int NUM_W       = ADC_BITS + R_SCALE_W;
    localparam int DEN_W       = ADC_BITS + 1;
    localparam int CNT_W       = $clog2(NUM_W + 1);

    // Curve table, 0 to 100 degrees in 5 degree steps
    localparam int NTC_ENTRIES = 21;
    localparam int IDX_W       = $clog2(NTC_ENTRIES);
    localparam int CURVE_W     = 12;
    localparam int STEP_TENTHS = 50;
    localparam int INTERP_W    = 15;

    // Result
    localparam int TEMP_W      = 10;
    localparam int TEMP_MAX    = 1000;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] RS_IN    = 2'd0;
    localparam logic [STATUS_W-1:0] RS_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] RS_ABOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RES,
        ST_SEARCH,
        ST_INTERP
    } t_state;

    // Divider control and status
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_ctrl;

    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] quo;
    } t_div_stat;

    // B3380 10k curve, 10 ohm units, descending
    function automatic logic [CURVE_W-1:0] ntc_curve(input logic [IDX_W-1:0] idx);
        logic [CURVE_W-1:0] v;
        case (idx)
            5'd0:    v = 12'd2749;
            5'd1:    v = 12'd2218;
            5'd2:    v = 12'd1802;
            5'd3:    v = 12'd1472;
            5'd4:    v = 12'd1210;
            5'd5:    v = 12'd1000;
            5'd6:    v = 12'd831;
            5'd7:    v = 12'd694;
            5'd8:    v = 12'd583;
            5'd9:    v = 12'd491;
            5'd10:   v = 12'd416;
            5'd11:   v = 12'd354;
            5'd12:   v = 12'd302;
            5'd13:   v = 12'd259;
            5'd14:   v = 12'd223;
            5'd15:   v = 12'd193;
            5'd16:   v = 12'd167;
            5'd17:   v = 12'd146;
            5'd18:   v = 12'd127;
            5'd19:   v = 12'd111;
            5'd20:   v = 12'd98;
            default: v = 12'd98;
        endcase
        return v;
    endfunction

endpackage

[src/ntc_if.sv]
// Valid/ready stream interfaces for the NTC converter input and result.
// Depends on ntc_pkg for field widths.
interface ntc_in_if;
    import ntc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntc_out_if;
    import ntc_pkg::*;

    logic                valid;
    logic                ready;
    logic [TEMP_W-1:0]   temp_tenths;
    logic [STATUS_W-1:0] range_status;

    modport source (output valid, output temp_tenths, output range_status, input ready);
    modport sink   (input valid, input temp_tenths, input range_status, output ready);
endinterface

[src/ntc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on ntc_pkg for widths and the control/status structs.
module ntc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ntc_pkg::t_div_ctrl i_ctrl,
    output ntc_pkg::t_div_stat o_stat
);
    import ntc_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: shift in the next numerator bit, try a subtract
    always_comb begin
        w_rem_sh = {r_rem, r_num[NUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
    end

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_num = r_num;
        n_quo = r_quo;
        n_den = r_den;
        if (i_ctrl.start) begin
            n_cnt = i_ctrl.iters;
            n_rem = '0;
            n_num = i_ctrl.num;
            n_quo = '0;
            n_den = i_ctrl.den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_quo = {r_quo[NUM_W-2:0], w_ge};
        end
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.quo  = r_quo;

endmodule

[src/ntc_adc_to_temperature_core.sv]
// NTC converter top level: sequencer, table search and result register.
// Each request makes one pass through the shared bit-serial divider (22 steps); an in-range
// request then takes up to 5 search steps and a second pass (15 steps). A new request is
// taken only in idle, once the previous result has been written to the output register.
// Reset: synchronous active low, clears the sequencer and the result valid flag.
module ntc_adc_to_temperature_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntc_in_if.sink    i_in,
    ntc_out_if.source o_out
);
    import ntc_pkg::*;

    t_state             r_state, n_state;
    logic [CURVE_W-1:0] r_res, n_res;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic               r_out_valid, n_out_valid;
    logic [TEMP_W-1:0]  r_temp, n_temp;
    logic [STATUS_W-1:0] r_status, n_status;

    t_div_ctrl          w_div_ctrl;
    t_div_stat          w_div_stat;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_wr;
    logic [NUM_W-1:0]   w_scaled;
    logic [DEN_W-1:0]   w_den_res;
    logic               w_res_high;
    logic               w_res_low;
    logic [IDX_W:0]     w_sum;
    logic [IDX_W-1:0]   w_mid;
    logic [IDX_W-1:0]   w_span;
    logic [CURVE_W-1:0] w_c_mid;
    logic [CURVE_W-1:0] w_c_lo;
    logic [CURVE_W-1:0] w_c_lo1;
    logic [CURVE_W-1:0] w_diff;
    logic [INTERP_W-1:0] w_interp_num;
    logic [TEMP_W-1:0]  w_temp_interp;

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .o_stat  (w_div_stat)
    );

    // Handshake helpers
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Resistance division operands
    assign w_scaled  = NUM_W'(i_in.adc_code) * NUM_W'(R_SCALE);
    assign w_den_res = DEN_W'(ADC_FULL) - DEN_W'(i_in.adc_code);

    // Range checks on the resistance quotient
    assign w_res_high = w_div_stat.quo > NUM_W'(ntc_curve(IDX_W'(0)));
    assign w_res_low  = w_div_stat.quo < NUM_W'(ntc_curve(IDX_W'(NTC_ENTRIES - 1)));

    // Search step and interpolation operands
    assign w_sum         = {1'b0, r_hi} + {1'b0, r_lo};
    assign w_mid         = w_sum[IDX_W:1];
    assign w_span        = r_hi - r_lo;
    assign w_c_mid       = ntc_curve(w_mid);
    assign w_c_lo        = ntc_curve(r_lo);
    assign w_c_lo1       = ntc_curve(IDX_W'(r_lo + 1'b1));
    assign w_diff        = w_c_lo - r_res;
    assign w_interp_num  = INTERP_W'(INTERP_W'(w_diff) * INTERP_W'(STEP_TENTHS));
    assign w_temp_interp = TEMP_W'(r_lo) * TEMP_W'(STEP_TENTHS) + TEMP_W'(w_div_stat.quo);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_temp     = r_temp;
        n_status   = r_status;
        w_out_wr   = 1'b0;
        w_div_ctrl.start = 1'b0;
        w_div_ctrl.iters = CNT_W'(NUM_W);
        w_div_ctrl.num   = w_scaled;
        w_div_ctrl.den   = w_den_res;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_div_ctrl.start = 1'b1;
                    n_state          = ST_RES;
                end
            end
            ST_RES: begin
                if (!w_div_stat.busy) begin
                    if (w_res_high) begin
                        if (w_out_free) begin
                            w_out_wr = 1'b1;
                            n_temp   = '0;
                            n_status = RS_BELOW;
                            n_state  = ST_IDLE;
                        end
                    end else if (w_res_low) begin
                        if (w_out_free) begin
                            w_out_wr = 1'b1;
                            n_temp   = TEMP_W'(TEMP_MAX);
                            n_status = RS_ABOVE;
                            n_state  = ST_IDLE;
                        end
                    end else begin
                        n_res   = CURVE_W'(w_div_stat.quo);
                        n_lo    = '0;
                        n_hi    = IDX_W'(NTC_ENTRIES - 1);
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_span > IDX_W'(1)) begin
                    if (w_c_mid < r_res) begin
                        n_hi = w_mid;
                    end else begin
                        n_lo = w_mid;
                    end
                end else begin
                    // segment found: divide for the fractional step
                    w_div_ctrl.start = 1'b1;
                    w_div_ctrl.iters = CNT_W'(INTERP_W);
                    w_div_ctrl.num   = {w_interp_num, {(NUM_W - INTERP_W){1'b0}}};
                    w_div_ctrl.den   = DEN_W'(w_c_lo - w_c_lo1);
                    n_state          = ST_INTERP;
                end
            end
            ST_INTERP: begin
                if (!w_div_stat.busy && w_out_free) begin
                    w_out_wr = 1'b1;
                    n_temp   = w_temp_interp;
                    n_status = RS_IN;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (w_out_wr) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_temp   <= n_temp;
        r_status <= n_status;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.temp_tenths  = r_temp;
    assign o_out.range_status = r_status;

endmodule

[src/ntc_chk.sv]
// Port-level checker for the NTC converter, bound to the top level.
// Depends on ntc_pkg and the assertion macros header.
`include "ntc_adc_to_temperature_core_defines.svh"

module ntc_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ntc_pkg::TEMP_W-1:0]   i_temp_tenths,
    input logic [ntc_pkg::STATUS_W-1:0] i_range_status
);
    import ntc_pkg::*;

    // A stalled result holds
    `NTC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_temp_tenths) && $stable(i_range_status))

    // One request in flight: ready drops after a request is taken
    `NTC_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Clamped results sit at the matching end of the range
    `NTC_ASSERT_IMP(a_clamp_value, i_clk, i_rst_n, i_out_valid && i_range_status != RS_IN, (i_range_status == RS_BELOW && i_temp_tenths == '0) || (i_range_status == RS_ABOVE && i_temp_tenths == TEMP_W'(TEMP_MAX)))

    // In-range results stay within the table span
    `NTC_ASSERT_IMP(a_temp_bound, i_clk, i_rst_n, i_out_valid && i_range_status == RS_IN, i_temp_tenths <= TEMP_W'(TEMP_MAX))

endmodule

bind ntc_adc_to_temperature_core ntc_chk u_ntc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_temp_tenths  (o_out.temp_tenths),
    .i_range_status (o_out.range_status)
);
